// File: rtl/cbqm_pkg.sv
// ============================================================================
// cbqm_pkg
// Shared types and constants for the contiguous buffer queue manager.
// ============================================================================
package cbqm_pkg;

    localparam int UNITS     = 64;
    localparam int QUEUES    = 4;
    localparam int UNIT_W    = $clog2(UNITS);
    localparam int CNT_W     = $clog2(UNITS + 1);
    localparam int QID_W     = 2;
    localparam int LEN_W     = 16;
    localparam int USZ_W     = 11;
    localparam int UIU_W     = 7;
    localparam int DIVD_W    = LEN_W + 1;
    localparam int DIV_STEPS = DIVD_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
    localparam int USZ_MAX   = 1024;

    localparam logic [2:0] CMD_CONNECT    = 3'd0;
    localparam logic [2:0] CMD_DISCONNECT = 3'd1;
    localparam logic [2:0] CMD_WRITE      = 3'd2;
    localparam logic [2:0] CMD_READ       = 3'd3;
    localparam logic [2:0] CMD_CLEAR      = 3'd4;
    localparam logic [2:0] CMD_UNBLK_RD   = 3'd5;
    localparam logic [2:0] CMD_UNBLK_WR   = 3'd6;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_NOT_CONNECTED = 3'd1;
    localparam logic [2:0] ST_NO_SPACE      = 3'd2;
    localparam logic [2:0] ST_NO_DATA       = 3'd3;
    localparam logic [2:0] ST_MUST_WAIT     = 3'd4;
    localparam logic [2:0] ST_BAD_LENGTH    = 3'd5;

    localparam logic [2:0] REG_UNIT_SIZE    = 3'd0;
    localparam logic [2:0] REG_UNITS_IN_USE = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_SCAN,
        S_MARK,
        S_COMMIT,
        S_FETCH,
        S_NODE,
        S_FREE,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        P_DONE,
        P_WRITE,
        P_WALK
    } path_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic div_step;
        logic scan_step;
        logic mark_step;
        logic commit;
        logic walk_fin;
        logic node;
        logic free_step;
    } ctrl_cmd_t;

    typedef struct packed {
        path_t path;
        logic  div_done;
        logic  scan_miss;
        logic  scan_hit;
        logic  mark_end;
        logic  walk_end;
        logic  node_free;
        logic  free_end;
        logic  walk_more;
    } dp_stat_t;

endpackage

// File: rtl/cbqm_ctrl.sv
// ============================================================================
// cbqm_ctrl
// Sequencer: steps one command transaction through divide, scan, mark,
// commit, queue walk and unit free phases.
// ============================================================================
module cbqm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  logic                slot_free,
    output logic                load_rsp,
    input  cbqm_pkg::dp_stat_t  stat,
    output cbqm_pkg::ctrl_cmd_t cmd
);
    import cbqm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd_ready  = 1'b0;
        load_rsp   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (stat.path)
                    P_WRITE: state_next = S_DIV;
                    P_WALK:  state_next = S_FETCH;
                    default: state_next = S_DONE;
                endcase
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_miss)
                begin
                    state_next = S_DONE;
                end
                else if (stat.scan_hit)
                begin
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                if (stat.mark_end)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd.mark_step = 1'b1;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_FETCH:
            begin
                if (stat.walk_end)
                begin
                    cmd.walk_fin = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_NODE;
                end
            end
            S_NODE:
            begin
                cmd.node   = 1'b1;
                state_next = stat.node_free ? S_FREE : S_FETCH;
            end
            S_FREE:
            begin
                if (stat.free_end)
                begin
                    state_next = stat.walk_more ? S_FETCH : S_DONE;
                end
                else
                begin
                    cmd.free_step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    load_rsp   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/cbqm_dp.sv
// ============================================================================
// cbqm_dp
// Datapath: unit bitmap, queue state, allocation memories, length divider,
// first-fit scan and result registers.
// ============================================================================
module cbqm_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cbqm_pkg::ctrl_cmd_t             cmd,
    output cbqm_pkg::dp_stat_t              stat,
    input  logic [2:0]                      command,
    input  logic [cbqm_pkg::QID_W-1:0]      queue_id,
    input  logic [cbqm_pkg::LEN_W-1:0]      byte_length,
    input  logic [cbqm_pkg::UNIT_W-1:0]     target_unit,
    input  logic                            may_block,
    input  logic [cbqm_pkg::USZ_W-1:0]      unit_size,
    input  logic [cbqm_pkg::UIU_W-1:0]      units_in_use,
    output logic [2:0]                      res_status,
    output logic [cbqm_pkg::UNIT_W-1:0]     res_start,
    output logic [cbqm_pkg::LEN_W-1:0]      res_length,
    output logic                            res_wake
);
    import cbqm_pkg::*;

    typedef struct packed {
        logic [LEN_W-1:0] bytes;
        logic [CNT_W-1:0] count;
    } meta_t;

    // Latched transaction
    logic [2:0]        cmd_reg;
    logic [QID_W-1:0]  q_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [UNIT_W-1:0] tgt_reg;
    logic              blk_reg;

    // Queue state
    logic [UNITS-1:0]  taken_reg;
    logic [UNIT_W-1:0] head_reg [QUEUES];
    logic [UNIT_W-1:0] tail_reg [QUEUES];
    logic [CNT_W-1:0]  ent_reg  [QUEUES];
    logic [QUEUES-1:0] conn_reg;
    logic [QUEUES-1:0] rw_reg;
    logic [QUEUES-1:0] ww_reg;

    // Allocation memories
    meta_t             meta_mem [UNITS];
    logic [UNIT_W-1:0] link_mem [UNITS];
    meta_t             meta_rd_reg;
    logic [UNIT_W-1:0] link_rd_reg;

    // Divider / scan / walk / free
    logic [USZ_W:0]    rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  run_reg;
    logic [UNIT_W-1:0] s_reg;
    logic [CNT_W-1:0]  mk_reg;
    logic [UNIT_W-1:0] u_reg;
    logic [UNIT_W-1:0] prev_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [UNIT_W-1:0] fbase_reg;
    logic [CNT_W-1:0]  fk_reg;
    logic [CNT_W-1:0]  fn_reg;

    logic [2:0]        st_reg;
    logic [UNIT_W-1:0] start_reg;
    logic [LEN_W-1:0]  olen_reg;
    logic              wake_reg;

    logic              qv;
    logic              conn;
    logic [USZ_W-1:0]  us;
    logic [CNT_W-1:0]  n_scan;
    logic [DIVD_W-1:0] dividend;
    logic [USZ_W:0]    dtry;
    logic [CNT_W-1:0]  run_next;
    logic [CNT_W:0]    fidx;
    logic              hit;
    logic [CNT_W-1:0]  ent_dec;
    logic [UNIT_W-1:0] mark_idx;

    assign qv   = (32'(q_reg) < QUEUES);
    assign conn = qv && conn_reg[q_reg];

    always_comb
    begin
        if (unit_size == '0)
        begin
            us = USZ_W'(1);
        end
        else if (unit_size > USZ_W'(USZ_MAX))
        begin
            us = USZ_W'(USZ_MAX);
        end
        else
        begin
            us = unit_size;
        end
        n_scan   = (units_in_use > UIU_W'(UNITS)) ? CNT_W'(UNITS) : CNT_W'(units_in_use);
        dividend = DIVD_W'(len_reg) + DIVD_W'(us) - DIVD_W'(1);
        dtry     = {rem_reg[USZ_W-1:0], quo_reg[DIVD_W-1]};
        run_next = taken_reg[idx_reg[UNIT_W-1:0]] ? '0 : run_reg + CNT_W'(1);
        fidx     = (CNT_W+1)'(fbase_reg) + (CNT_W+1)'(fk_reg);
        hit      = (cmd_reg == CMD_READ) || ((cmd_reg == CMD_CLEAR) && (u_reg == tgt_reg));
        ent_dec  = ent_reg[q_reg] - CNT_W'(1);
        mark_idx = UNIT_W'(s_reg + UNIT_W'(mk_reg));
    end

    always_comb
    begin
        stat.path = P_DONE;
        case (cmd_reg)
            CMD_DISCONNECT: stat.path = conn ? P_WALK : P_DONE;
            CMD_WRITE:      stat.path = (conn && len_reg != '0) ? P_WRITE : P_DONE;
            CMD_READ:       stat.path = (conn && ent_reg[q_reg] != '0) ? P_WALK : P_DONE;
            CMD_CLEAR:      stat.path = qv ? P_WALK : P_DONE;
            default:        stat.path = P_DONE;
        endcase
        stat.div_done  = (dcnt_reg == DCNT_W'(DIV_STEPS));
        stat.scan_miss = (idx_reg >= n_scan);
        stat.scan_hit  = !stat.scan_miss && ((DIVD_W'(run_next)) == quo_reg);
        stat.mark_end  = (mk_reg == quo_reg[CNT_W-1:0]);
        stat.walk_end  = (k_reg >= cnt_reg);
        stat.node_free = hit || (cmd_reg == CMD_DISCONNECT);
        stat.free_end  = (fk_reg >= fn_reg) || (fidx >= (CNT_W+1)'(UNITS));
        stat.walk_more = (cmd_reg == CMD_DISCONNECT);
    end

    // Memories: registered read at the current walk node
    always_ff @(posedge clk)
    begin
        meta_rd_reg <= meta_mem[u_reg];
        link_rd_reg <= link_mem[u_reg];
        if (cmd.commit)
        begin
            meta_mem[s_reg] <= '{bytes: len_reg, count: quo_reg[CNT_W-1:0]};
            if (ent_reg[q_reg] != '0)
            begin
                link_mem[tail_reg[q_reg]] <= s_reg;
            end
        end
        else if (cmd.node && hit && k_reg != '0)
        begin
            link_mem[prev_reg] <= link_rd_reg;
        end
    end

    // Working registers without reset
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg <= command;
            q_reg   <= queue_id;
            len_reg <= byte_length;
            tgt_reg <= target_unit;
            blk_reg <= may_block;
        end
        if (cmd.exec)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dcnt_reg <= '0;
            idx_reg  <= '0;
            run_reg  <= '0;
            u_reg    <= head_reg[q_reg];
            prev_reg <= '0;
            k_reg    <= '0;
            cnt_reg  <= ent_reg[q_reg];
        end
        if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
            if (dtry >= (USZ_W+1)'(us))
            begin
                rem_reg <= dtry - (USZ_W+1)'(us);
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= dtry;
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b0};
            end
        end
        if (cmd.scan_step && !stat.scan_miss)
        begin
            run_reg <= run_next;
            idx_reg <= idx_reg + CNT_W'(1);
            s_reg   <= UNIT_W'(idx_reg + CNT_W'(1) - quo_reg[CNT_W-1:0]);
            mk_reg  <= '0;
        end
        if (cmd.mark_step)
        begin
            mk_reg <= mk_reg + CNT_W'(1);
        end
        if (cmd.node)
        begin
            fbase_reg <= u_reg;
            fn_reg    <= meta_rd_reg.count;
            fk_reg    <= '0;
            if (!hit)
            begin
                u_reg <= link_rd_reg;
                k_reg <= k_reg + CNT_W'(1);
                if (cmd_reg == CMD_CLEAR)
                begin
                    prev_reg <= u_reg;
                end
            end
        end
        if (cmd.free_step)
        begin
            fk_reg <= fk_reg + CNT_W'(1);
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            st_reg    <= ST_OK;
            start_reg <= '0;
            olen_reg  <= '0;
            wake_reg  <= 1'b0;
            case (cmd_reg)
                CMD_DISCONNECT:
                begin
                    if (!conn)
                    begin
                        st_reg <= ST_NOT_CONNECTED;
                    end
                    else
                    begin
                        wake_reg <= rw_reg[q_reg] | ww_reg[q_reg];
                    end
                end
                CMD_WRITE:
                begin
                    if (!conn)
                    begin
                        st_reg <= ST_NOT_CONNECTED;
                    end
                    else if (len_reg == '0)
                    begin
                        st_reg <= ST_BAD_LENGTH;
                    end
                end
                CMD_READ:
                begin
                    if (!conn)
                    begin
                        st_reg <= ST_NOT_CONNECTED;
                    end
                    else if (ent_reg[q_reg] == '0)
                    begin
                        st_reg <= blk_reg ? ST_MUST_WAIT : ST_NO_DATA;
                    end
                end
                CMD_UNBLK_RD:   wake_reg <= qv && rw_reg[q_reg];
                CMD_UNBLK_WR:   wake_reg <= qv && ww_reg[q_reg];
                default:        st_reg <= ST_OK;
            endcase
        end
        if (cmd.scan_step && stat.scan_miss)
        begin
            st_reg <= blk_reg ? ST_MUST_WAIT : ST_NO_SPACE;
        end
        if (cmd.commit)
        begin
            start_reg <= s_reg;
            wake_reg  <= rw_reg[q_reg];
        end
        if (cmd.node && hit)
        begin
            start_reg <= u_reg;
            wake_reg  <= ww_reg[q_reg];
            if (cmd_reg == CMD_READ)
            begin
                olen_reg <= meta_rd_reg.bytes;
            end
        end
    end

    // Control state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
            conn_reg  <= '0;
            rw_reg    <= '0;
            ww_reg    <= '0;
            for (int i = 0; i < QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                ent_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.exec && qv)
            begin
                case (cmd_reg)
                    CMD_CONNECT:    conn_reg[q_reg] <= 1'b1;
                    CMD_DISCONNECT:
                    begin
                        if (conn)
                        begin
                            rw_reg[q_reg] <= 1'b0;
                            ww_reg[q_reg] <= 1'b0;
                        end
                    end
                    CMD_WRITE:      ww_reg[q_reg] <= 1'b0;
                    CMD_READ:
                    begin
                        rw_reg[q_reg] <= conn && ent_reg[q_reg] == '0 && blk_reg;
                    end
                    CMD_UNBLK_RD:   rw_reg[q_reg] <= 1'b0;
                    CMD_UNBLK_WR:   ww_reg[q_reg] <= 1'b0;
                    default:        conn_reg[q_reg] <= conn_reg[q_reg];
                endcase
            end
            if (cmd.scan_step && stat.scan_miss && blk_reg)
            begin
                ww_reg[q_reg] <= 1'b1;
            end
            if (cmd.mark_step)
            begin
                taken_reg[mark_idx] <= 1'b1;
            end
            if (cmd.commit)
            begin
                if (ent_reg[q_reg] == '0)
                begin
                    head_reg[q_reg] <= s_reg;
                end
                tail_reg[q_reg] <= s_reg;
                ent_reg[q_reg]  <= ent_reg[q_reg] + CNT_W'(1);
            end
            if (cmd.node && hit)
            begin
                ent_reg[q_reg] <= ent_dec;
                if (ent_dec == '0)
                begin
                    head_reg[q_reg] <= '0;
                    tail_reg[q_reg] <= '0;
                end
                else
                begin
                    if (k_reg == '0)
                    begin
                        head_reg[q_reg] <= link_rd_reg;
                    end
                    if (k_reg == cnt_reg - CNT_W'(1))
                    begin
                        tail_reg[q_reg] <= prev_reg;
                    end
                end
            end
            if (cmd.walk_fin && cmd_reg == CMD_DISCONNECT)
            begin
                ent_reg[q_reg]  <= '0;
                head_reg[q_reg] <= '0;
                tail_reg[q_reg] <= '0;
                conn_reg[q_reg] <= 1'b0;
            end
            if (cmd.free_step)
            begin
                taken_reg[fidx[UNIT_W-1:0]] <= 1'b0;
            end
        end
    end

    assign res_status = st_reg;
    assign res_start  = start_reg;
    assign res_length = olen_reg;
    assign res_wake   = wake_reg;

endmodule

// File: rtl/contiguous_buffer_queue_manager.sv
// ============================================================================
// contiguous_buffer_queue_manager
// First-fit unit allocator for a buffer memory shared by several queues.
// ============================================================================
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  command   | cmd_valid/cmd_ready  | command queue_id byte_length target_unit
//            |                      | may_block
//  response  | rsp_valid/rsp_ready  | status start_unit out_length wake
//  config    | psel/penable/pready  | paddr pwdata prdata (APB)
//
//  One transaction at a time. A write divides the length by the unit
//  size, scans the units first-fit and, on a hit, marks the run of
//  units and commits it. Read, clear and disconnect walk the queue
//  node by node and free the units of each allocation they release.
//  The response register lets a new transaction enter while the last
//  response waits. Reset returns all queues empty and disconnected; no
//  clearing pass.
// ============================================================================
module contiguous_buffer_queue_manager (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  logic [2:0]                      command,
    input  logic [cbqm_pkg::QID_W-1:0]      queue_id,
    input  logic [cbqm_pkg::LEN_W-1:0]      byte_length,
    input  logic [cbqm_pkg::UNIT_W-1:0]     target_unit,
    input  logic                            may_block,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [2:0]                      status,
    output logic [cbqm_pkg::UNIT_W-1:0]     start_unit,
    output logic [cbqm_pkg::LEN_W-1:0]      out_length,
    output logic                            wake,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import cbqm_pkg::*;

    ctrl_cmd_t         cmd;
    dp_stat_t          stat;
    logic              load_rsp;
    logic              slot_free;
    logic [USZ_W-1:0]  usz_reg;
    logic [UIU_W-1:0]  uiu_reg;
    logic              rsp_valid_reg;
    logic [2:0]        res_status;
    logic [UNIT_W-1:0] res_start;
    logic [LEN_W-1:0]  res_length;
    logic              res_wake;
    logic [2:0]        status_reg;
    logic [UNIT_W-1:0] start_reg;
    logic [LEN_W-1:0]  length_reg;
    logic              wake_reg;

    assign pready    = 1'b1;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usz_reg <= USZ_W'(32);
            uiu_reg <= UIU_W'(UNITS);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_UNITS_IN_USE[2])
            begin
                uiu_reg <= pwdata[UIU_W-1:0];
            end
            else
            begin
                usz_reg <= pwdata[USZ_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_UNITS_IN_USE[2]) ? 32'(uiu_reg) : 32'(usz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (load_rsp)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            status_reg <= res_status;
            start_reg  <= res_start;
            length_reg <= res_length;
            wake_reg   <= res_wake;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign start_unit = start_reg;
    assign out_length = length_reg;
    assign wake       = wake_reg;

    cbqm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .slot_free (slot_free),
        .load_rsp  (load_rsp),
        .stat      (stat),
        .cmd       (cmd)
    );

    cbqm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .command      (command),
        .queue_id     (queue_id),
        .byte_length  (byte_length),
        .target_unit  (target_unit),
        .may_block    (may_block),
        .unit_size    (usz_reg),
        .units_in_use (uiu_reg),
        .res_status   (res_status),
        .res_start    (res_start),
        .res_length   (res_length),
        .res_wake     (res_wake)
    );

endmodule
